[rtl/tcw_pkg.sv]
package tcw_pkg;

  localparam int COLUMNS   = 80;
  localparam int ROWS      = 25;
  localparam int CELLS     = COLUMNS * ROWS;
  localparam int COL_W     = $clog2(COLUMNS);
  localparam int COL_CNT_W = $clog2(COLUMNS + 1);
  localparam int ROW_W     = $clog2(ROWS);
  localparam int ROW_CNT_W = $clog2(ROWS + 1);
  localparam int ADDR_W    = $clog2(CELLS);
  localparam int CELL_W    = 16;

  localparam int OP_W      = 1;
  localparam int CHAR_W    = 8;
  localparam int ATTR_W    = 8;
  localparam int IDX_W     = 11;
  localparam int OCOL_W    = 7;
  localparam int OROW_W    = 5;
  localparam int S_DATA_W  = 24;
  localparam int M_DATA_W  = 32;

  localparam int TAB_STOP  = 4;
  localparam int TAB_MASK  = TAB_STOP - 1;

  localparam logic [OP_W-1:0]   OP_PUT     = 1'b0;
  localparam logic [OP_W-1:0]   OP_READ    = 1'b1;
  localparam logic [CHAR_W-1:0] CH_NL      = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_TAB     = 8'h09;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'h20;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAB,
    ST_SCR_RD,
    ST_SCR_WR,
    ST_DONE
  } st_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic             vld;
    logic             rd_hit;
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } res_t;

endpackage

[rtl/text_console_writer.sv]
// A printed byte, carriage return, newline or read is accepted in ST_IDLE; its result waits in
// ST_DONE for the output register. A tab writes 1 to 4 space cells; wrapping past the last row adds
// a scroll: cells move up a row over the single cell store port pair and the last row is cleared.
// Throughput: one item at a time; the next item is taken once the result is in the output register.
// Reset: asynchronous, active low; afterwards a clearing pass zeroes all CELLS cells of the
// store with s_axis_tready low; configuration writes are taken throughout.
module text_console_writer (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tcw_pkg::ATTR_W-1:0]     cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // char_code[7:0], cell_index[18:8], zero pad
  input  logic [tcw_pkg::S_DATA_W-1:0]   s_axis_tdata,
  // opcode[0]
  input  logic [tcw_pkg::OP_W-1:0]       s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // cursor_col[6:0], cursor_row[11:7], cell_char[19:12], cell_attr[27:20], zero pad
  output logic [tcw_pkg::M_DATA_W-1:0]   m_axis_tdata
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] attr_q;
  ram_req_t          ram_req;
  res_t              res;
  logic              res_ready;
  logic [CELL_W-1:0] rdata;

  logic              out_vld_q;
  logic [OCOL_W-1:0] out_col_q;
  logic [OROW_W-1:0] out_row_q;
  logic [CHAR_W-1:0] out_char_q;
  logic [ATTR_W-1:0] out_attr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_valid_i) begin
      attr_q <= cfg_data_i;
    end
  end

  tcw_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .opcode_i     (s_axis_tuser),
    .char_code_i  (s_axis_tdata[CHAR_W-1:0]),
    .cell_index_i (s_axis_tdata[CHAR_W+IDX_W-1:CHAR_W]),
    .attr_i       (attr_q),
    .rdata_i      (rdata),
    .ram_req_o    (ram_req),
    .res_o        (res),
    .res_ready_i  (res_ready)
  );

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .re_i    (ram_req.re),
    .raddr_i (ram_req.raddr),
    .rdata_o (rdata)
  );

  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res.vld && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.vld && res_ready) begin
      out_col_q  <= OCOL_W'(res.col);
      out_row_q  <= OROW_W'(res.row);
      out_char_q <= res.rd_hit ? rdata[CHAR_W-1:0] : '0;
      out_attr_q <= res.rd_hit ? rdata[CELL_W-1:CHAR_W] : '0;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {
    (M_DATA_W - OCOL_W - OROW_W - CHAR_W - ATTR_W)'(0),
    out_attr_q, out_char_q, out_row_q, out_col_q
  };

endmodule

[rtl/tcw_ram.sv]
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/tcw_seq.sv]
module tcw_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [tcw_pkg::OP_W-1:0]       opcode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]     char_code_i,
  input  logic [tcw_pkg::IDX_W-1:0]      cell_index_i,
  input  logic [tcw_pkg::ATTR_W-1:0]     attr_i,
  input  logic [tcw_pkg::CELL_W-1:0]     rdata_i,
  output tcw_pkg::ram_req_t              ram_req_o,
  output tcw_pkg::res_t                  res_o,
  input  logic                           res_ready_i
);
  import tcw_pkg::*;

  st_e               state_q, state_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [ADDR_W-1:0] base_q, base_d;
  logic [COL_W-1:0]  col_q, col_d;
  logic [ROW_W-1:0]  row_q, row_d;
  logic              busy_q, busy_d;
  logic              rd_hit_q, rd_hit_d;

  logic [COL_CNT_W-1:0] col_inc;
  logic [ROW_CNT_W-1:0] row_inc;
  logic                 wrap;
  logic                 last_row;
  logic                 do_step;
  logic                 do_wrap;
  logic [ADDR_W-1:0]    pos;

  assign col_inc  = COL_CNT_W'(col_q) + COL_CNT_W'(1);
  assign row_inc  = ROW_CNT_W'(row_q) + ROW_CNT_W'(1);
  assign wrap     = (col_inc == COL_CNT_W'(COLUMNS));
  assign last_row = (row_inc == ROW_CNT_W'(ROWS));
  assign pos      = base_q + ADDR_W'(col_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_CLEAR;
      ptr_q    <= '0;
      base_q   <= '0;
      col_q    <= '0;
      row_q    <= '0;
      busy_q   <= 1'b0;
      rd_hit_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      ptr_q    <= ptr_d;
      base_q   <= base_d;
      col_q    <= col_d;
      row_q    <= row_d;
      busy_q   <= busy_d;
      rd_hit_q <= rd_hit_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    base_d     = base_q;
    col_d      = col_q;
    row_d      = row_q;
    busy_d     = busy_q;
    rd_hit_d   = rd_hit_q;
    ram_req_o  = '0;
    in_ready_o = 1'b0;
    do_step    = 1'b0;
    do_wrap    = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = ptr_q;
        ram_req_o.wdata = '0;
        if (ptr_q == ADDR_W'(CELLS - 1)) begin
          state_d = busy_q ? ST_DONE : ST_IDLE;
        end else begin
          ptr_d = ptr_q + ADDR_W'(1);
        end
      end
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          busy_d   = 1'b1;
          rd_hit_d = 1'b0;
          state_d  = ST_DONE;
          if (opcode_i == OP_READ) begin
            rd_hit_d        = (32'(cell_index_i) < CELLS);
            ram_req_o.re    = 1'b1;
            ram_req_o.raddr = ADDR_W'(cell_index_i);
          end else begin
            case (char_code_i)
              CH_NL:   do_wrap = 1'b1;
              CH_CR:   col_d   = '0;
              CH_TAB:  state_d = ST_TAB;
              default: begin
                ram_req_o.we    = 1'b1;
                ram_req_o.waddr = pos;
                ram_req_o.wdata = {attr_i, char_code_i};
                do_step         = 1'b1;
              end
            endcase
          end
        end
      end
      ST_TAB: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = pos;
        ram_req_o.wdata = {attr_i, CH_SPACE};
        do_step         = 1'b1;
        if (!wrap && ((COL_W'(col_inc) & COL_W'(TAB_MASK)) != '0)) begin
          state_d = ST_TAB;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_SCR_RD: begin
        ram_req_o.re    = 1'b1;
        ram_req_o.raddr = ptr_q + ADDR_W'(COLUMNS);
        state_d         = ST_SCR_WR;
      end
      ST_SCR_WR: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = ptr_q;
        ram_req_o.wdata = rdata_i;
        if (ptr_q == ADDR_W'(CELLS - COLUMNS - 1)) begin
          ptr_d   = ADDR_W'(CELLS - COLUMNS);
          state_d = ST_CLEAR;
        end else begin
          ptr_d   = ptr_q + ADDR_W'(1);
          state_d = ST_SCR_RD;
        end
      end
      ST_DONE: begin
        if (res_ready_i) begin
          busy_d  = 1'b0;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (do_step && !wrap) begin
      col_d = COL_W'(col_inc);
    end
    if (do_wrap || (do_step && wrap)) begin
      col_d = '0;
      if (last_row) begin
        row_d   = ROW_W'(ROWS - 1);
        base_d  = ADDR_W'(CELLS - COLUMNS);
        ptr_d   = '0;
        state_d = ST_SCR_RD;
      end else begin
        row_d  = ROW_W'(row_inc);
        base_d = base_q + ADDR_W'(COLUMNS);
      end
    end
  end

  assign res_o.vld    = (state_q == ST_DONE);
  assign res_o.rd_hit = rd_hit_q;
  assign res_o.col    = col_q;
  assign res_o.row    = row_q;

  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_req_o.we && ram_req_o.re))
    else $error("cell store read and write in one cycle");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCR_RD) |-> (col_q == '0 && row_q == ROW_W'(ROWS - 1)))
    else $error("cursor not parked on last row during scroll");

  a_wr_follows_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCR_WR) |-> ($past(state_q) == ST_SCR_RD))
    else $error("scroll write without read");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_req_o.we |-> (32'(ram_req_o.waddr) < CELLS))
    else $error("cell store write out of range");

  a_busy_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |-> busy_q)
    else $error("result without item");

endmodule
